// ----- hw/rtl/nqai_pkg.sv -----
// ----------------------------------------------------------------------------
// nqai_pkg
// Shared widths, step counts and operation codes of the angle interpolator.
// ----------------------------------------------------------------------------
package nqai_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned DEN_W    = 17;
    localparam int unsigned FRAC_W   = 15;
    localparam int unsigned VALUE_W  = 16;
    localparam int unsigned DIV_CNT_W = $clog2(WORD_W);
    localparam int unsigned MUL_STEPS = DEN_W;
    localparam int unsigned MUL_CNT_W = $clog2(MUL_STEPS);

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef enum logic [6:0] {
        t_st_idle = 7'b0000001,
        t_st_div1 = 7'b0000010,
        t_st_div2 = 7'b0000100,
        t_st_div3 = 7'b0001000,
        t_st_mul1 = 7'b0010000,
        t_st_mul2 = 7'b0100000,
        t_st_wout = 7'b1000000
    } t_state;

endpackage

// ----- hw/rtl/nqai_div.sv -----
// ----------------------------------------------------------------------------
// nqai_div
// Bit-serial signed divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module nqai_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [nqai_pkg::WORD_W-1:0] i_num,
    input  logic [nqai_pkg::DEN_W-1:0]  i_den,
    output logic                        o_done,
    output logic [nqai_pkg::WORD_W-1:0] o_quot
);
    import nqai_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [WORD_W-1:0]    r_q;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_den;
    logic                 r_neg;
    logic [DEN_W:0]       rem_sh;
    logic                 ge;
    logic [DEN_W:0]       rem_sub;

    assign rem_sh  = {r_rem, r_q[WORD_W-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[WORD_W-1];
            r_q   <= i_num[WORD_W-1] ? (~i_num + 1'b1) : i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_q   <= {r_q[WORD_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = (r_den == '0) ? '0 : (r_neg ? (~r_q + 1'b1) : r_q);

endmodule

// ----- hw/rtl/nqai_mul.sv -----
// ----------------------------------------------------------------------------
// nqai_mul
// Bit-serial multiply-accumulate: acc + mcand * mplr, modulo 2^32.
// ----------------------------------------------------------------------------
module nqai_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [nqai_pkg::WORD_W-1:0] i_acc,
    input  logic [nqai_pkg::WORD_W-1:0] i_mcand,
    input  logic [nqai_pkg::DEN_W-1:0]  i_mplr,
    output logic                        o_done,
    output logic [nqai_pkg::WORD_W-1:0] o_acc
);
    import nqai_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [WORD_W-1:0]    r_acc;
    logic [WORD_W-1:0]    r_mcand;
    logic [DEN_W-1:0]     r_mplr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CNT_W'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc   <= i_acc;
            r_mcand <= i_mcand;
            r_mplr  <= i_mplr;
        end else if (r_busy) begin
            if (r_mplr[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand <= {r_mcand[WORD_W-2:0], 1'b0};
            r_mplr  <= {1'b0, r_mplr[DEN_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

// ----- hw/rtl/newton_quadratic_angle_interpolator.sv -----
// ----------------------------------------------------------------------------
// newton_quadratic_angle_interpolator
// Quadratic Newton upsampler for a wrapping Q15 angle.
// ----------------------------------------------------------------------------
// The input channel carries samples (operation 0) and ticks (operation 1).
// A sample transfer produces no result; a tick transfer produces one
// interpolated angle on the output channel.
// One item is worked on at a time: the next input transfer is taken only
// back in idle. A sample runs three 32-step serial divisions; a tick runs
// two 17-step serial multiply-accumulates while running and none while
// frozen.
// The finished result sits in an output register, so the next input transfer
// is taken while that result waits. If the receiver stalls and a second
// result is finished, the block waits until the first one is taken.
// Reset clears the history, coefficients and tick count, sets both segment
// lengths of each bank to one and starts frozen on a zero angle.
// ----------------------------------------------------------------------------
module newton_quadratic_angle_interpolator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_operation,
    input  logic signed [15:0]           i_sample_value,
    input  logic [14:0]                  i_segment_length,
    input  logic                         i_direction,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [15:0]           o_interpolated_value
);
    import nqai_pkg::*;

    t_state              r_state;
    logic [WORD_W-1:0]   r_h    [3];
    logic [WORD_W-1:0]   r_coef [2][3];
    logic [LEN_W-1:0]    r_len  [2][2];
    logic                r_act;
    logic [LEN_W-1:0]    r_tick;
    logic                r_upd;
    logic                r_run;
    logic                r_sub;
    logic [WORD_W-1:0]   r_d1;
    logic [WORD_W-1:0]   r_slope;
    logic [VALUE_W-1:0]  r_res;
    logic                r_ovalid;
    logic [VALUE_W-1:0]  r_out;

    logic                div_start;
    logic                div_done;
    logic                mul_start;
    logic                mul_done;
    logic [WORD_W-1:0]   div_num;
    logic [DEN_W-1:0]    div_den;
    logic [WORD_W-1:0]   div_quot;
    logic [WORD_W-1:0]   mul_acc_in;
    logic [WORD_W-1:0]   mul_mcand;
    logic [DEN_W-1:0]    mul_mplr;
    logic [WORD_W-1:0]   mul_acc;

    logic                in_xfer;
    logic                idle;
    logic [WORD_W-1:0]   h1_new;
    logic [WORD_W-1:0]   h2_raw;
    logic [WORD_W-1:0]   h2_new;
    logic [LEN_W-1:0]    tick_inc;
    logic                out_free;

    assign idle       = (r_state == t_st_idle);
    assign o_in_ready = idle;
    assign in_xfer    = i_in_valid && idle;
    assign out_free   = !r_ovalid || i_out_ready;

    assign h1_new = {r_h[2][30], r_h[2][30:15], {FRAC_W{1'b0}}};
    assign h2_raw = {i_sample_value[15], i_sample_value, {FRAC_W{1'b0}}};

    always_comb begin
        h2_new = h2_raw;
        if (($signed(h2_raw) > $signed(h1_new)) && i_direction) begin
            h2_new[WORD_W-1] = ~h2_raw[WORD_W-1];
        end else if (($signed(h1_new) > $signed(h2_raw)) && !i_direction) begin
            h2_new[WORD_W-1] = ~h2_raw[WORD_W-1];
        end
    end

    assign tick_inc = r_tick + 1'b1;

    always_comb begin
        div_num = r_h[1] - r_h[0];
        div_den = {1'b0, r_len[~r_act][0]};
        unique case (r_state)
            t_st_div2: begin
                div_num = r_h[2] - r_h[1];
                div_den = {1'b0, r_len[~r_act][1]};
            end
            t_st_div3: begin
                div_num = r_slope - r_d1;
                div_den = {1'b0, r_len[~r_act][0]} + {1'b0, r_len[~r_act][1]};
            end
            default: begin
            end
        endcase
        div_start = !r_sub && (r_state == t_st_div1 || r_state == t_st_div2
                               || r_state == t_st_div3);
    end

    always_comb begin
        mul_acc_in = r_coef[r_act][1];
        mul_mcand  = r_coef[r_act][2];
        mul_mplr   = {1'b0, r_tick};
        if (r_state == t_st_mul2) begin
            mul_acc_in = r_coef[r_act][0];
            mul_mcand  = mul_acc;
            mul_mplr   = {1'b0, r_tick} + {1'b0, r_len[r_act][0]};
        end
        mul_start = !r_sub && (r_state == t_st_mul1 || r_state == t_st_mul2);
    end

    nqai_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    nqai_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_acc   (mul_acc_in),
        .i_mcand (mul_mcand),
        .i_mplr  (mul_mplr),
        .o_done  (mul_done),
        .o_acc   (mul_acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= t_st_idle;
            r_sub    <= 1'b0;
            r_ovalid <= 1'b0;
            r_act    <= 1'b0;
            r_tick   <= '0;
            r_upd    <= 1'b0;
            r_run    <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_h[i]       <= '0;
                r_coef[0][i] <= '0;
                r_coef[1][i] <= '0;
            end
            for (int b = 0; b < 2; b++) begin
                r_len[b][0] <= LEN_W'(1);
                r_len[b][1] <= LEN_W'(1);
            end
        end else begin
            if (r_state == t_st_wout && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (div_start || mul_start) begin
                r_sub <= 1'b1;
            end
            unique case (r_state)
                t_st_idle: begin
                    if (in_xfer) begin
                        if (i_operation == OP_SAMPLE) begin
                            r_h[0] <= r_h[1];
                            r_h[1] <= h1_new;
                            r_h[2] <= h2_new;
                            r_len[~r_act][0] <= r_len[r_act][1];
                            r_len[~r_act][1] <= {1'b0, i_segment_length};
                            r_state <= t_st_div1;
                        end else if (r_run) begin
                            r_state <= t_st_mul1;
                        end else begin
                            r_res   <= r_h[2][30:15];
                            r_state <= t_st_wout;
                        end
                    end
                end
                t_st_div1: begin
                    if (div_done) begin
                        r_d1    <= div_quot;
                        r_sub   <= 1'b0;
                        r_state <= t_st_div2;
                    end
                end
                t_st_div2: begin
                    if (div_done) begin
                        r_slope <= div_quot;
                        r_sub   <= 1'b0;
                        r_state <= t_st_div3;
                    end
                end
                t_st_div3: begin
                    if (div_done) begin
                        r_coef[~r_act][0] <= r_h[0];
                        r_coef[~r_act][1] <= r_d1;
                        r_coef[~r_act][2] <= div_quot;
                        r_upd   <= 1'b1;
                        r_run   <= 1'b1;
                        r_sub   <= 1'b0;
                        r_state <= t_st_idle;
                    end
                end
                t_st_mul1: begin
                    if (mul_done) begin
                        r_sub   <= 1'b0;
                        r_state <= t_st_mul2;
                    end
                end
                t_st_mul2: begin
                    if (mul_done) begin
                        r_sub   <= 1'b0;
                        r_res   <= mul_acc[30:15];
                        r_tick  <= ((tick_inc >= r_len[r_act][1]) && r_upd) ? '0 : tick_inc;
                        if (tick_inc >= r_len[r_act][1]) begin
                            if (r_upd) begin
                                r_act  <= ~r_act;
                                r_upd  <= 1'b0;
                            end else begin
                                r_h[0] <= r_h[1];
                                r_h[1] <= r_h[2];
                                r_run  <= 1'b0;
                            end
                        end
                        r_state <= t_st_wout;
                    end
                end
                t_st_wout: begin
                    if (out_free) begin
                        r_out    <= r_res;
                        r_state  <= t_st_idle;
                    end
                end
                default: begin
                    r_state <= t_st_idle;
                end
            endcase
        end
    end

    assign o_out_valid          = r_ovalid;
    assign o_interpolated_value = r_out;

endmodule
